@@ hw/rtl/wdsg_pkg.sv @@
// ----------------------------------------------------------------------------
// wdsg_pkg: shared types and constants of the wheel drive safety governor
// Command codes, register indexes, reset values and the records passed
// between the governor's sub-blocks.
// ----------------------------------------------------------------------------
package wdsg_pkg;

	// Depth of the over-current incident history; entry 0 is the newest
	localparam int INCIDENT_DEPTH = 4;
	localparam int RAMP_STEP      = 20;

	// Command codes of an input request
	localparam logic [1:0] CMD_TICK       = 2'd0;
	localparam logic [1:0] CMD_DRIVE      = 2'd1;
	localparam logic [1:0] CMD_DISCONNECT = 2'd2;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_LIMIT   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_TIMEOUT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INCIDENT_WINDOW = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_CAP       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_RAMP_ENABLE     = 3'd4;

	// Register reset values
	localparam logic [9:0]  RST_CURRENT_LIMIT   = 10'd512;
	localparam logic [31:0] RST_COMMAND_TIMEOUT = 32'd1000;
	localparam logic [31:0] RST_INCIDENT_WINDOW = 32'd10000;
	localparam logic [7:0]  RST_SPEED_CAP       = 8'd255;
	localparam logic        RST_RAMP_ENABLE     = 1'b0;

	typedef struct packed {
		logic [9:0]  current_limit;
		logic [31:0] command_timeout_ms;
		logic [31:0] incident_window_ms;
		logic [7:0]  speed_cap;
		logic        ramp_enable;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [31:0]        time_ms;
		logic signed [15:0] left_command;
		logic signed [15:0] right_command;
		logic [9:0]         left_current;
		logic [9:0]         right_current;
		logic               left_bumper_pressed;
		logic               right_bumper_pressed;
	} item_t;

	typedef struct packed {
		logic signed [8:0]                 left_target;
		logic signed [8:0]                 right_target;
		logic signed [8:0]                 left_speed;
		logic signed [8:0]                 right_speed;
		logic [31:0]                       last_command_time;
		logic [INCIDENT_DEPTH-1:0][31:0]   incident_history;
		logic                              left_dir;
		logic                              right_dir;
	} state_t;

	typedef struct packed {
		logic [7:0] left_pwm;
		logic [7:0] right_pwm;
		logic       left_reverse;
		logic       right_reverse;
		logic       light_on;
		logic       derated;
		logic       halted;
		logic       bumper_hold;
	} result_t;

endpackage

@@ hw/rtl/wdsg_cfg.sv @@
// ----------------------------------------------------------------------------
// wdsg_cfg: configuration register bank
// Holds the five governor settings; a write request is always taken.
// ----------------------------------------------------------------------------
module wdsg_cfg import wdsg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Write the addressed register; unknown indexes drop the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_limit      <= RST_CURRENT_LIMIT;
			cfg_q.command_timeout_ms <= RST_COMMAND_TIMEOUT;
			cfg_q.incident_window_ms <= RST_INCIDENT_WINDOW;
			cfg_q.speed_cap          <= RST_SPEED_CAP;
			cfg_q.ramp_enable        <= RST_RAMP_ENABLE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CURRENT_LIMIT:   cfg_q.current_limit      <= cfg_data[9:0];
				REG_COMMAND_TIMEOUT: cfg_q.command_timeout_ms <= cfg_data;
				REG_INCIDENT_WINDOW: cfg_q.incident_window_ms <= cfg_data;
				REG_SPEED_CAP:       cfg_q.speed_cap          <= cfg_data[7:0];
				REG_RAMP_ENABLE:     cfg_q.ramp_enable        <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/wdsg_step.sv @@
// ----------------------------------------------------------------------------
// wdsg_step: next-state and result logic for one request
// Applies a drive command, a disconnect or a control tick to the wheel state
// and forms the result record from the state after the request.
// ----------------------------------------------------------------------------
module wdsg_step import wdsg_pkg::*; (
	input  state_t  cur,
	input  item_t   item,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t res
);

	// Scale by 4/5 toward zero: |v|*4/5 as |v|*820 >> 10, exact below 256
	function automatic logic signed [8:0] derate(input logic signed [8:0] v);
		logic [8:0]  m;
		logic [17:0] p;
		logic [8:0]  q;
		m = v[8] ? 9'(-v) : 9'(v);
		p = 18'(m) * 18'd820;
		q = {1'b0, p[17:10]};
		return v[8] ? $signed(-q) : $signed(q);
	endfunction

	// Limit a requested speed to plus or minus max speed
	function automatic logic signed [8:0] clamp_cmd(input logic signed [15:0] c,
			input logic [7:0] lim);
		logic signed [16:0] c17;
		logic signed [16:0] m17;
		c17 = 17'(c);
		m17 = $signed({9'd0, lim});
		if (c17 > m17) return m17[8:0];
		else if (c17 < -m17) return 9'(-m17);
		return c17[8:0];
	endfunction

	// Step the speed at most RAMP_STEP toward the target
	function automatic logic signed [8:0] approach(input logic signed [8:0] spd,
			input logic signed [8:0] tgt);
		logic signed [9:0] d;
		logic signed [9:0] s;
		d = 10'(tgt) - 10'(spd);
		if (d > 10'(RAMP_STEP)) d = 10'(RAMP_STEP);
		else if (d < -10'(RAMP_STEP)) d = -10'(RAMP_STEP);
		s = 10'(spd) + d;
		return s[8:0];
	endfunction

	function automatic logic dir_of(input logic signed [8:0] v, input logic held);
		if (v > 0) return 1'b0;
		else if (v < 0) return 1'b1;
		return held;
	endfunction

	logic                            tk_over;
	logic [INCIDENT_DEPTH-1:0][31:0] tk_hist;
	logic [31:0]                     tk_cmd_diff;
	logic [31:0]                     tk_inc_diff;
	logic                            tk_halt;
	logic signed [8:0]               tk_lt1, tk_rt1;
	logic signed [8:0]               tk_lt2, tk_rt2, tk_ls2, tk_rs2;
	logic signed [8:0]               tk_ls3, tk_rs3;
	logic                            tk_pressed;
	logic                            tk_bump;

	// Over-current check: derate targets and push the tick time
	assign tk_over = (item.left_current > cfg.current_limit) ||
	                 (item.right_current > cfg.current_limit);
	assign tk_lt1  = tk_over ? derate(cur.left_target)  : cur.left_target;
	assign tk_rt1  = tk_over ? derate(cur.right_target) : cur.right_target;

	always_comb begin
		tk_hist = cur.incident_history;
		if (tk_over) begin
			tk_hist[0] = item.time_ms;
			for (int i = 1; i < INCIDENT_DEPTH; i++) begin
				tk_hist[i] = cur.incident_history[i-1];
			end
		end
	end

	// Halt on command timeout or a full history inside the window
	assign tk_cmd_diff = item.time_ms - cur.last_command_time;
	assign tk_inc_diff = item.time_ms - tk_hist[INCIDENT_DEPTH-1];
	assign tk_halt = (tk_cmd_diff > cfg.command_timeout_ms) ||
	                 ((item.time_ms > cfg.incident_window_ms) &&
	                  (tk_inc_diff < cfg.incident_window_ms));
	assign tk_lt2 = tk_halt ? 9'sd0 : tk_lt1;
	assign tk_rt2 = tk_halt ? 9'sd0 : tk_rt1;
	assign tk_ls2 = tk_halt ? 9'sd0 : cur.left_speed;
	assign tk_rs2 = tk_halt ? 9'sd0 : cur.right_speed;

	// Ramp or copy speeds toward the targets
	assign tk_ls3 = cfg.ramp_enable ? approach(tk_ls2, tk_lt2) : tk_lt2;
	assign tk_rs3 = cfg.ramp_enable ? approach(tk_rs2, tk_rt2) : tk_rt2;

	// Bumper removes forward speed and forward targets
	assign tk_pressed = item.left_bumper_pressed || item.right_bumper_pressed;
	assign tk_bump = tk_pressed && ((tk_ls3 > 0) || (tk_rs3 > 0) ||
	                                (tk_lt2 > 0) || (tk_rt2 > 0));

	// Select the update for the request's command
	always_comb begin
		nxt         = cur;
		res.derated = 1'b0;
		res.halted  = 1'b0;
		res.bumper_hold = 1'b0;
		unique case (item.cmd)
			CMD_DRIVE: begin
				nxt.last_command_time = item.time_ms;
				nxt.left_target  = clamp_cmd(item.left_command, cfg.speed_cap);
				nxt.right_target = clamp_cmd(item.right_command, cfg.speed_cap);
			end
			CMD_DISCONNECT: begin
				nxt.left_target  = 9'sd0;
				nxt.right_target = 9'sd0;
				nxt.left_speed   = 9'sd0;
				nxt.right_speed  = 9'sd0;
			end
			CMD_TICK: begin
				nxt.incident_history = tk_hist;
				nxt.left_target  = (tk_pressed && tk_lt2 > 0) ? 9'sd0 : tk_lt2;
				nxt.right_target = (tk_pressed && tk_rt2 > 0) ? 9'sd0 : tk_rt2;
				nxt.left_speed   = (tk_pressed && tk_ls3 > 0) ? 9'sd0 : tk_ls3;
				nxt.right_speed  = (tk_pressed && tk_rs3 > 0) ? 9'sd0 : tk_rs3;
				nxt.left_dir  = dir_of(nxt.left_speed, cur.left_dir);
				nxt.right_dir = dir_of(nxt.right_speed, cur.right_dir);
				res.derated     = tk_over;
				res.halted      = tk_halt;
				res.bumper_hold = tk_bump;
			end
			default: ;
		endcase

		// Show the wheel outputs after the request
		res.left_pwm  = nxt.left_speed[8]  ? 8'(-nxt.left_speed)  : nxt.left_speed[7:0];
		res.right_pwm = nxt.right_speed[8] ? 8'(-nxt.right_speed) : nxt.right_speed[7:0];
		res.left_reverse  = nxt.left_dir;
		res.right_reverse = nxt.right_dir;
		res.light_on = (nxt.left_speed != 9'sd0) || (nxt.right_speed != 9'sd0);
	end

endmodule

@@ hw/rtl/wheel_drive_safety_governor.sv @@
// ----------------------------------------------------------------------------
// wheel_drive_safety_governor: two-wheel drive governor
// Clamps drive commands, derates on over-current, halts on command timeout
// or repeated incidents, ramps speeds and applies the bumpers.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    cmd, time_ms, commands, currents, bumpers
//  out      out_valid / out_stall  pwm, reverse, light_on, derated, halted,
//                                  bumper_hold
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle sustained while results are taken; an accepted request
// passes the input register, then the state and result registers.
// The whole update sits in one pass of logic between those registers.
// Reset restores the register defaults and clears all wheel state at once.
// A stalled result holds; the input register still takes one more request,
// then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module wheel_drive_safety_governor import wdsg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             cmd,
	input  logic [31:0]            time_ms,
	input  logic signed [15:0]     left_command,
	input  logic signed [15:0]     right_command,
	input  logic [9:0]             left_current,
	input  logic [9:0]             right_current,
	input  logic                   left_bumper_pressed,
	input  logic                   right_bumper_pressed,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             left_pwm,
	output logic [7:0]             right_pwm,
	output logic                   left_reverse,
	output logic                   right_reverse,
	output logic                   light_on,
	output logic                   derated,
	output logic                   halted,
	output logic                   bumper_hold,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;
	logic    fire;

	wdsg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wdsg_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Process the held request once the result slot is free
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;

	// Capture an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.cmd                  <= cmd;
			item_s1.time_ms              <= time_ms;
			item_s1.left_command         <= left_command;
			item_s1.right_command        <= right_command;
			item_s1.left_current         <= left_current;
			item_s1.right_current        <= right_current;
			item_s1.left_bumper_pressed  <= left_bumper_pressed;
			item_s1.right_bumper_pressed <= right_bumper_pressed;
		end
	end

	// Advance the wheel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_pwm      = res_q.left_pwm;
	assign right_pwm     = res_q.right_pwm;
	assign left_reverse  = res_q.left_reverse;
	assign right_reverse = res_q.right_reverse;
	assign light_on      = res_q.light_on;
	assign derated       = res_q.derated;
	assign halted        = res_q.halted;
	assign bumper_hold   = res_q.bumper_hold;

endmodule

@@ hw/rtl/wdsg_checker.sv @@
// ----------------------------------------------------------------------------
// wdsg_checker: port-level checks of the wheel drive safety governor
// Watches the top level's ports and reports violations by $error.
// ----------------------------------------------------------------------------
module wdsg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] left_pwm,
	input logic [7:0] right_pwm,
	input logic       light_on,
	input logic       halted
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_pwm) && $stable(right_pwm))
		else $error("stalled result changed");

	// Input backs up only behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free result slot");

	// Light follows the wheel magnitudes
	a_light: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> light_on == ((left_pwm != 8'd0) || (right_pwm != 8'd0)))
		else $error("light flag disagrees with wheel outputs");

	// A halt leaves both wheels stopped
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halted |-> (left_pwm == 8'd0) && (right_pwm == 8'd0))
		else $error("halted result with wheel speed");

endmodule

bind wheel_drive_safety_governor wdsg_checker u_wdsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.left_pwm  (left_pwm),
	.right_pwm (right_pwm),
	.light_on  (light_on),
	.halted    (halted)
);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the wheel drive safety governor
// Drives drive commands, disconnects, control ticks and unused codes through the request
// channel with random gaps and random result back-pressure. A behavioural
// copy of the governor predicts every result, which is checked field by
// field against the block. Register settings change between phases,
// extremes included.
// ----------------------------------------------------------------------------
module tb;
	import wdsg_pkg::*;

	localparam logic [1:0] CMD_UNUSED      = 2'd3;
	localparam int         ITEMS_PER_PHASE = 250;
	localparam int         PHASES          = 8;
	localparam int         HOLD_CYCLES     = 120;
	localparam int         SETTLE_CYCLES   = 6;
	localparam int unsigned CYCLE_LIMIT    = 1000000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [1:0]             cmd = '0;
	logic [31:0]            time_ms = '0;
	logic signed [15:0]     left_command = '0;
	logic signed [15:0]     right_command = '0;
	logic [9:0]             left_current = '0;
	logic [9:0]             right_current = '0;
	logic                   left_bumper_pressed = 1'b0;
	logic                   right_bumper_pressed = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [7:0]             left_pwm;
	logic [7:0]             right_pwm;
	logic                   left_reverse;
	logic                   right_reverse;
	logic                   light_on;
	logic                   derated;
	logic                   halted;
	logic                   bumper_hold;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0]            cfg_data = '0;

	wheel_drive_safety_governor dut (.*);

	// Clock
	always #4 clk = ~clk;

	// Governor copy: settings and wheel state
	cfg_t        gov_cfg;
	int          left_tgt, right_tgt, left_spd, right_spd;
	logic [31:0] last_drive_ms;
	logic [31:0] incidents [INCIDENT_DEPTH];
	logic        left_rev, right_rev;

	// Stimulus and bookkeeping
	item_t       request_queue [$];
	result_t     expected_wheel_outputs [$];
	item_t       offered;
	logic [31:0] clock_ms;
	int unsigned queued_total = 0;
	int unsigned accepted_total = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          req_taken = 1'b0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	int          gap_left = 0;
	int          hold_left = 0;
	int          stall_left = 0;
	int          free_left = 0;

	function automatic int limit_speed(int v, int cap);
		if (v > cap) return cap;
		if (v < -cap) return -cap;
		return v;
	endfunction

	function automatic int ramp_towards(int cur, int tgt);
		int d;
		d = tgt - cur;
		if (d > RAMP_STEP) d = RAMP_STEP;
		if (d < -RAMP_STEP) d = -RAMP_STEP;
		return cur + d;
	endfunction

	function automatic logic [7:0] speed_magnitude(int v);
		int m;
		m = (v < 0) ? -v : v;
		return m[7:0];
	endfunction

	// Apply one request to the governor copy and return the wheel outputs it shows
	function automatic result_t advance_governor(item_t req);
		result_t     res;
		int          cap, i;
		logic [31:0] cmd_age, incident_age;
		res = '0;
		cap = gov_cfg.speed_cap;
		case (req.cmd)
		CMD_DRIVE: begin
			last_drive_ms = req.time_ms;
			left_tgt = limit_speed($signed(req.left_command), cap);
			right_tgt = limit_speed($signed(req.right_command), cap);
		end
		CMD_DISCONNECT: begin
			left_tgt = 0;
			right_tgt = 0;
			left_spd = 0;
			right_spd = 0;
		end
		CMD_TICK: begin
			// derate on over-current and log the incident
			if (req.left_current > gov_cfg.current_limit ||
					req.right_current > gov_cfg.current_limit) begin
				left_tgt = (left_tgt * 4) / 5;
				right_tgt = (right_tgt * 4) / 5;
				for (i = INCIDENT_DEPTH - 1; i > 0; i--)
					incidents[i] = incidents[i - 1];
				incidents[0] = req.time_ms;
				res.derated = 1'b1;
			end
			// halt on command timeout or a crowded incident history
			cmd_age = req.time_ms - last_drive_ms;
			incident_age = req.time_ms - incidents[INCIDENT_DEPTH - 1];
			if (cmd_age > gov_cfg.command_timeout_ms ||
					(req.time_ms > gov_cfg.incident_window_ms &&
					incident_age < gov_cfg.incident_window_ms)) begin
				left_tgt = 0;
				right_tgt = 0;
				left_spd = 0;
				right_spd = 0;
				res.halted = 1'b1;
			end
			if (gov_cfg.ramp_enable) begin
				left_spd = ramp_towards(left_spd, left_tgt);
				right_spd = ramp_towards(right_spd, right_tgt);
			end else begin
				left_spd = left_tgt;
				right_spd = right_tgt;
			end
			// drop forward motion while a bumper is pressed
			if (req.left_bumper_pressed || req.right_bumper_pressed) begin
				if (right_spd > 0) begin right_spd = 0; res.bumper_hold = 1'b1; end
				if (left_spd > 0) begin left_spd = 0; res.bumper_hold = 1'b1; end
				if (right_tgt > 0) begin right_tgt = 0; res.bumper_hold = 1'b1; end
				if (left_tgt > 0) begin left_tgt = 0; res.bumper_hold = 1'b1; end
			end
			if (left_spd > 0) left_rev = 1'b0;
			else if (left_spd < 0) left_rev = 1'b1;
			if (right_spd > 0) right_rev = 1'b0;
			else if (right_spd < 0) right_rev = 1'b1;
		end
		default: ;
		endcase
		res.left_pwm = speed_magnitude(left_spd);
		res.right_pwm = speed_magnitude(right_spd);
		res.left_reverse = left_rev;
		res.right_reverse = right_rev;
		res.light_on = (left_spd != 0) || (right_spd != 0);
		return res;
	endfunction

	function automatic string show_result(result_t r);
		return $sformatf("pwm %0d/%0d rev %b/%b light %b derated %b halted %b bump %b",
			r.left_pwm, r.right_pwm, r.left_reverse, r.right_reverse, r.light_on,
			r.derated, r.halted, r.bumper_hold);
	endfunction

	function automatic int pick_pause();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic item_t make_req(input logic [1:0] op, input logic [31:0] at_ms,
			input logic [15:0] lcmd, input logic [15:0] rcmd,
			input logic [9:0] lcur, input logic [9:0] rcur,
			input logic lbump, input logic rbump);
		item_t it;
		it.cmd = op;
		it.time_ms = at_ms;
		it.left_command = lcmd;
		it.right_command = rcmd;
		it.left_current = lcur;
		it.right_current = rcur;
		it.left_bumper_pressed = lbump;
		it.right_bumper_pressed = rbump;
		return it;
	endfunction

	// Mostly a plausible stream of commands and ticks on a running clock,
	// with some fully random noise mixed in
	function automatic item_t random_request();
		item_t it;
		int    r, v, lim;
		lim = gov_cfg.current_limit;
		if ($urandom_range(0, 99) < 8) begin
			return make_req(2'($urandom_range(0, 3)), $urandom, 16'($urandom),
				16'($urandom), 10'($urandom_range(0, 1023)),
				10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end
		if ($urandom_range(0, 99) < 2) clock_ms += $urandom_range(1000, 5000);
		else clock_ms += $urandom_range(0, 40);
		it.time_ms = clock_ms;
		r = $urandom_range(0, 99);
		if (r < 22) it.cmd = CMD_DRIVE;
		else if (r < 25) it.cmd = CMD_DISCONNECT;
		else if (r < 27) it.cmd = CMD_UNUSED;
		else it.cmd = CMD_TICK;
		if ($urandom_range(0, 99) < 80) begin
			v = $urandom_range(0, 640);
			it.left_command = 16'(v - 320);
			v = $urandom_range(0, 640);
			it.right_command = 16'(v - 320);
		end else begin
			it.left_command = 16'($urandom);
			it.right_command = 16'($urandom);
		end
		if ($urandom_range(0, 99) < 15 && lim < 1023) begin
			it.left_current = 10'($urandom_range(lim + 1, 1023));
			it.right_current = 10'($urandom_range(0, 1023));
		end else begin
			it.left_current = 10'($urandom_range(0, lim));
			it.right_current = 10'($urandom_range(0, lim));
		end
		if ($urandom_range(0, 1)) begin
			v = it.left_current;
			it.left_current = it.right_current;
			it.right_current = 10'(v);
		end
		it.left_bumper_pressed = ($urandom_range(0, 99) < 8);
		it.right_bumper_pressed = ($urandom_range(0, 99) < 8);
		return it;
	endfunction

	function automatic void offer(item_t it);
		request_queue.push_back(it);
		queued_total++;
	endfunction

	// Wait until every request is taken and every result has arrived
	task automatic wait_idle();
		do @(negedge clk);
		while (accepted_total != queued_total || expected_wheel_outputs.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
		REG_CURRENT_LIMIT:   gov_cfg.current_limit = value[9:0];
		REG_COMMAND_TIMEOUT: gov_cfg.command_timeout_ms = value;
		REG_INCIDENT_WINDOW: gov_cfg.incident_window_ms = value;
		REG_SPEED_CAP:       gov_cfg.speed_cap = value[7:0];
		REG_RAMP_ENABLE:     gov_cfg.ramp_enable = value[0];
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [9:0] limit, input logic [31:0] timeout,
			input logic [31:0] window, input logic [7:0] cap, input logic ramp);
		write_reg(REG_CURRENT_LIMIT, 32'(limit));
		write_reg(REG_COMMAND_TIMEOUT, timeout);
		write_reg(REG_INCIDENT_WINDOW, window);
		write_reg(REG_SPEED_CAP, 32'(cap));
		write_reg(REG_RAMP_ENABLE, 32'(ramp));
	endtask

	// Request driver: hold a stalled request, otherwise idle or present the next one
	always @(negedge clk) begin : request_driver
		if (arst_n && !(in_valid && !req_taken)) begin
			req_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (request_queue.size() > 0) begin
				offered = request_queue.pop_front();
				cmd <= offered.cmd;
				time_ms <= offered.time_ms;
				left_command <= offered.left_command;
				right_command <= offered.right_command;
				left_current <= offered.left_current;
				right_current <= offered.right_current;
				left_bumper_pressed <= offered.left_bumper_pressed;
				right_bumper_pressed <= offered.right_bumper_pressed;
				in_valid <= 1'b1;
				gap_left = pick_pause();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result back-pressure: random stalls plus an occasional long hold-off
	always @(negedge clk) begin : result_stall
		logic hold_now;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			hold_now = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			hold_now = 1'b1;
		end else if (free_left > 0) begin
			free_left--;
			hold_now = 1'b0;
		end else begin
			stall_left = pick_pause();
			free_left = quiet ? 0 : $urandom_range(0, 6);
			hold_now = (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
		out_stall <= hold_now;
	end

	// Check results against the oldest prediction, then predict accepted requests
	always @(posedge clk) begin : scoreboard
		result_t got, want;
		string   bad;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.left_pwm = left_pwm;
				got.right_pwm = right_pwm;
				got.left_reverse = left_reverse;
				got.right_reverse = right_reverse;
				got.light_on = light_on;
				got.derated = derated;
				got.halted = halted;
				got.bumper_hold = bumper_hold;
				if (expected_wheel_outputs.size() == 0) begin
					if (mismatch_count < 10)
						$display("cycle %0d: result with nothing expected: %s",
							cycle_count, show_result(got));
					mismatch_count++;
				end else begin
					want = expected_wheel_outputs.pop_front();
					bad = "";
					if (got.left_pwm !== want.left_pwm) bad = {bad, " left_pwm"};
					if (got.right_pwm !== want.right_pwm) bad = {bad, " right_pwm"};
					if (got.left_reverse !== want.left_reverse) bad = {bad, " left_reverse"};
					if (got.right_reverse !== want.right_reverse) bad = {bad, " right_reverse"};
					if (got.light_on !== want.light_on) bad = {bad, " light_on"};
					if (got.derated !== want.derated) bad = {bad, " derated"};
					if (got.halted !== want.halted) bad = {bad, " halted"};
					if (got.bumper_hold !== want.bumper_hold) bad = {bad, " bumper_hold"};
					if (bad != "") begin
						if (mismatch_count < 10)
							$display("cycle %0d: mismatch in%s\n  expected %s\n  actual   %s",
								cycle_count, bad, show_result(want), show_result(got));
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_wheel_outputs.push_back(advance_governor(offered));
				accepted_total++;
				req_taken = 1'b1;
			end
		end
	end

	// Reset, directed requests, then random phases under changing settings
	initial begin : stimulus
		int phase, n, i;
		gov_cfg.current_limit = RST_CURRENT_LIMIT;
		gov_cfg.command_timeout_ms = RST_COMMAND_TIMEOUT;
		gov_cfg.incident_window_ms = RST_INCIDENT_WINDOW;
		gov_cfg.speed_cap = RST_SPEED_CAP;
		gov_cfg.ramp_enable = RST_RAMP_ENABLE;
		left_tgt = 0;
		right_tgt = 0;
		left_spd = 0;
		right_spd = 0;
		last_drive_ms = '0;
		for (i = 0; i < INCIDENT_DEPTH; i++) incidents[i] = '0;
		left_rev = 1'b0;
		right_rev = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: clamps, current threshold, bumpers, timeout edge, incident halt, wrap
		offer(make_req(CMD_TICK, 32'd0, 16'h0000, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0));
		offer(make_req(CMD_DRIVE, 32'd10, 16'h7FFF, 16'h8000, 10'd1023, 10'd1023, 1'b1, 1'b1));
		offer(make_req(CMD_TICK, 32'd20, 16'h0000, 16'h0000, 10'd512, 10'd512, 1'b0, 1'b0));
		offer(make_req(CMD_TICK, 32'd30, 16'h0000, 16'h0000, 10'd1023, 10'd0, 1'b0, 1'b0));
		offer(make_req(CMD_TICK, 32'd40, 16'h0000, 16'h0000, 10'd0, 10'd513, 1'b0, 1'b0));
		offer(make_req(CMD_TICK, 32'd50, 16'h0000, 16'h0000, 10'd0, 10'd0, 1'b1, 1'b0));
		offer(make_req(CMD_DRIVE, 32'd60, 16'hFFFF, 16'h0001, 10'd0, 10'd0, 1'b0, 1'b0));
		offer(make_req(CMD_TICK, 32'd70, 16'h0000, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b1));
		offer(make_req(CMD_TICK, 32'd1061, 16'h0000, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0));
		offer(make_req(CMD_DRIVE, 32'd1100, 16'd100, 16'hFF9C, 10'd0, 10'd0, 1'b0, 1'b0));
		offer(make_req(CMD_TICK, 32'd2100, 16'h0000, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0));
		offer(make_req(CMD_DISCONNECT, 32'd2100, 16'h5555, 16'hAAAA, 10'd1023, 10'd1023,
			1'b1, 1'b1));
		offer(make_req(CMD_UNUSED, 32'd2101, 16'h1234, 16'hEDCB, 10'd1023, 10'd1023,
			1'b1, 1'b1));
		offer(make_req(CMD_DRIVE, 32'd20000, 16'd300, 16'hFED4, 10'd0, 10'd0, 1'b0, 1'b0));
		for (i = 0; i < INCIDENT_DEPTH; i++)
			offer(make_req(CMD_TICK, 32'd20000 + i, 16'h0000, 16'h0000, 10'd600, 10'd0,
				1'b0, 1'b0));
		offer(make_req(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023,
			1'b1, 1'b1));
		offer(make_req(CMD_DRIVE, 32'hFFFF_FFFF, 16'h00C8, 16'hFF38, 10'd0, 10'd0,
			1'b0, 1'b0));
		offer(make_req(CMD_TICK, 32'd0, 16'h0000, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0));
		offer(make_req(CMD_TICK, 32'd5, 16'h0000, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0));
		clock_ms = 32'd50000;

		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
			0: apply_settings(10'd1023, 32'hFFFF_FFFF, 32'd0, 8'd255, 1'b1);
			1: apply_settings(10'd0, 32'd0, 32'hFFFF_FFFF, 8'd0, 1'b0);
			2: apply_settings(10'd400, 32'd2000, 32'd800, 8'd255, 1'b1);
			default: apply_settings(10'($urandom_range(300, 900)), $urandom_range(200, 3000),
				$urandom_range(100, 6000), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
			endcase
			// run one phase across the 32-bit wrap of the clock
			if (phase == 3) clock_ms = 32'hFFFF_F800;
			quiet = (phase == 6);
			// hold results off long enough to back the block up into its input
			if (phase == 4) hold_req = 1'b1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 5 && n == ITEMS_PER_PHASE / 2) wait_idle();
				offer(random_request());
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_wheel_outputs.size() != 0) begin
			$display("%0d results never arrived", expected_wheel_outputs.size());
			mismatch_count += expected_wheel_outputs.size();
		end
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
